@@ hdl/bis_pkg.sv @@
// package for the bilinear rgba image scaler
// shared constants, payload structs and states; no dependencies
package bis_pkg;

  localparam int MAX_SRC_WIDTH  = 1024;
  localparam int MAX_SRC_HEIGHT = 512;
  localparam int MAX_DST_WIDTH  = 1024;
  localparam int MAX_DST_HEIGHT = 512;
  localparam int FRAC_BITS      = 16;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_W = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_H = 2'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       last_pixel;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_ADDR, ST_READ, ST_WAIT, ST_HORZ, ST_BLEND
  } state_t;

endpackage

@@ hdl/bis_lane.sv @@
// one channel lane: two-step bilinear blend with half-up rounding
// depends on bis_pkg
module bis_lane #(
  parameter int FB = bis_pkg::FRAC_BITS
) (
  input  logic          clk,
  input  logic [7:0]    p00,
  input  logic [7:0]    p10,
  input  logic [7:0]    p01,
  input  logic [7:0]    p11,
  input  logic [FB-1:0] fx,
  input  logic [FB-1:0] fy,
  output logic [7:0]    pix
);
  localparam logic [FB:0] ONE  = (FB+1)'(1) << FB;
  localparam logic [FB+8:0] HALF = (FB+9)'(1) << (FB-1);

  logic [7:0] top, bot;
  logic [FB+8:0] top_sum, bot_sum, v_sum;

  // horizontal pass, registered before the vertical pass
  assign top_sum = (FB+9)'(p00) * (FB+9)'(ONE - {1'b0, fx}) + (FB+9)'(p10) * (FB+9)'(fx)
                 + HALF;
  assign bot_sum = (FB+9)'(p01) * (FB+9)'(ONE - {1'b0, fx}) + (FB+9)'(p11) * (FB+9)'(fx)
                 + HALF;

  always_ff @(posedge clk) begin
    top <= top_sum[FB+7:FB];
    bot <= bot_sum[FB+7:FB];
  end

  assign v_sum = (FB+9)'(top) * (FB+9)'(ONE - {1'b0, fy}) + (FB+9)'(bot) * (FB+9)'(fy)
               + HALF;
  assign pix = v_sum[FB+7:FB];
endmodule

@@ hdl/bis_div.sv @@
// restoring divider for the corner-aligned source position
// no dependencies
module bis_div #(
  parameter int NW = 32,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          done
);
  localparam int CW = $clog2(NW+1);
  logic [NW-1:0] q;
  logic [DW:0]   rem;
  logic [DW:0]   trial;
  logic [CW-1:0] cnt;
  logic          run;
  logic [DW-1:0] d;

  assign trial = {rem[DW-1:0], q[NW-1]};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CW'(NW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q   <= num;
      rem <= '0;
      d   <= den;
    end else if (run) begin
      if (trial >= {1'b0, d}) begin
        rem <= trial - {1'b0, d};
        q   <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[NW-2:0], 1'b0};
      end
    end
  end
endmodule

@@ hdl/bilinear_rgba_image_scaler.sv @@
// bilinear rgba image scaler, top level; depends on bis_pkg, bis_div, bis_lane
// load transaction: written to the store at the accepting edge, busy stays low, one per cycle while busy is low
// emit transaction: busy while two serial position divisions (NW = 38 at default sizes),
//   the address step, four reads, a wait and two blend steps run
// result strobe in the first cycle with busy low after the emit
// rst is synchronous: clears counters, sizes to defaults and the sequencer; store undefined
module bilinear_rgba_image_scaler #(
  parameter int MAX_SRC_WIDTH  = bis_pkg::MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = bis_pkg::MAX_SRC_HEIGHT,
  parameter int MAX_DST_WIDTH  = bis_pkg::MAX_DST_WIDTH,
  parameter int MAX_DST_HEIGHT = bis_pkg::MAX_DST_HEIGHT,
  parameter int FRAC_BITS      = bis_pkg::FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  bis_pkg::in_item_t                   in_item,
  output logic                                done,
  output bis_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0]      cfg_data
);
  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SWW   = $clog2(MAX_SRC_WIDTH+1);
  localparam int SHW   = $clog2(MAX_SRC_HEIGHT+1);
  localparam int TWW   = $clog2(MAX_DST_WIDTH+1);
  localparam int THW   = $clog2(MAX_DST_HEIGHT+1);
  localparam int TCW   = (TWW > THW) ? TWW : THW;
  localparam int SCW   = (SWW > SHW) ? SWW : SHW;
  // product t*(s-1) width, then numerator t*(s-1)<<frac, divider width
  localparam int PW    = TCW + SCW;
  localparam int NW    = PW + FRAC_BITS;
  localparam int LPW   = AW + 1;

  // config registers as written (raw 11 / 10 bit)
  logic [10:0] reg_sw, reg_tw;
  logic [9:0]  reg_sh, reg_th;
  logic [SWW-1:0] sw;
  logic [SHW-1:0] sh;
  logic [TWW-1:0] tw;
  logic [THW-1:0] th;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_sw <= 11'd1024;
      reg_sh <= 10'd256;
      reg_tw <= 11'd512;
      reg_th <= 10'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bis_pkg::REG_SRC_W: reg_sw <= cfg_data;
        bis_pkg::REG_SRC_H: reg_sh <= cfg_data[9:0];
        bis_pkg::REG_DST_W: reg_tw <= cfg_data;
        bis_pkg::REG_DST_H: reg_th <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    sw = (reg_sw == 11'd0) ? SWW'(1) : (32'(reg_sw) > MAX_SRC_WIDTH)  ? SWW'(MAX_SRC_WIDTH)
       : SWW'(reg_sw);
    sh = (reg_sh == 10'd0) ? SHW'(1) : (32'(reg_sh) > MAX_SRC_HEIGHT) ? SHW'(MAX_SRC_HEIGHT)
       : SHW'(reg_sh);
    tw = (reg_tw == 11'd0) ? TWW'(1) : (32'(reg_tw) > MAX_DST_WIDTH)  ? TWW'(MAX_DST_WIDTH)
       : TWW'(reg_tw);
    th = (reg_th == 10'd0) ? THW'(1) : (32'(reg_th) > MAX_DST_HEIGHT) ? THW'(MAX_DST_HEIGHT)
       : THW'(reg_th);
  end

  // frame store, one write and one read port
  logic [31:0] store [DEPTH];
  logic [31:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [LPW-1:0] load_position, total, pos, pos_inc;
  logic accept;

  assign accept = start && !busy;
  assign total = LPW'(sw) * LPW'(sh);
  assign pos = (load_position < total) ? load_position : '0;
  assign pos_inc = pos + 1'b1;

  always_ff @(posedge clk) begin
    if (accept && in_item.command == bis_pkg::CMD_LOAD)
      store[pos[AW-1:0]] <= {in_item.in_alpha, in_item.in_blue, in_item.in_green,
                             in_item.in_red};
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) load_position <= '0;
    else if (accept && in_item.command == bis_pkg::CMD_LOAD)
      load_position <= (pos_inc >= total) ? '0 : pos_inc;
  end

  // emit sequencer
  bis_pkg::state_t state, state_next;
  logic [TWW-1:0] out_column, xc;
  logic [THW-1:0] out_row, yc;
  logic axis;          // 0 x division, 1 y division
  logic [1:0] rd_idx;  // which corner is being read
  logic [NW-1:0] xf, yf;
  logic [SWW-1:0] x0, x1;
  logic [SHW-1:0] y0, y1;
  logic [31:0] px [4];
  logic div_go, div_done;
  logic [NW-1:0] num, quo;
  logic [SCW:0] den;
  logic last_r;

  assign xc = (out_column < tw) ? out_column : '0;
  assign yc = (out_row < th) ? out_row : '0;

  // x division starts from idle, y division starts once x is done
  always_comb begin
    if (state == bis_pkg::ST_IDLE) begin
      num = {PW'(xc) * PW'(sw - 1'b1), {FRAC_BITS{1'b0}}};
      den = (SCW+1)'(tw - 1'b1);
    end else begin
      num = {PW'(yc) * PW'(sh - 1'b1), {FRAC_BITS{1'b0}}};
      den = (SCW+1)'(th - 1'b1);
    end
  end

  bis_div #(.NW(NW), .DW(SCW+1)) u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(num), .den(den), .quo(quo), .done(div_done)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bis_pkg::ST_IDLE:  if (accept && in_item.command == bis_pkg::CMD_EMIT)
                           state_next = bis_pkg::ST_DIV;
      bis_pkg::ST_DIV:   if (div_done && axis) state_next = bis_pkg::ST_ADDR;
      bis_pkg::ST_ADDR:  state_next = bis_pkg::ST_READ;
      bis_pkg::ST_READ:  if (rd_idx == 2'd3) state_next = bis_pkg::ST_WAIT;
      bis_pkg::ST_WAIT:  state_next = bis_pkg::ST_HORZ;
      bis_pkg::ST_HORZ:  state_next = bis_pkg::ST_BLEND;
      bis_pkg::ST_BLEND: state_next = bis_pkg::ST_IDLE;
      default:           state_next = bis_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy   = (state != bis_pkg::ST_IDLE);
    div_go = (state == bis_pkg::ST_IDLE && accept && in_item.command == bis_pkg::CMD_EMIT)
          || (state == bis_pkg::ST_DIV && div_done && !axis);
    unique case (rd_idx)
      2'd0:    rd_addr = AW'(y0) * AW'(sw) + AW'(x0);
      2'd1:    rd_addr = AW'(y0) * AW'(sw) + AW'(x1);
      2'd2:    rd_addr = AW'(y1) * AW'(sw) + AW'(x0);
      default: rd_addr = AW'(y1) * AW'(sw) + AW'(x1);
    endcase
  end

  logic [NW-1:0] xi, yi;
  assign xi = (tw <= TWW'(1)) ? '0 : xf;
  assign yi = (th <= THW'(1)) ? '0 : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bis_pkg::ST_IDLE;
      axis <= 1'b0;
      rd_idx <= '0;
      out_column <= '0;
      out_row <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == bis_pkg::ST_BLEND);
      if (div_go) axis <= (state == bis_pkg::ST_DIV);
      if (state == bis_pkg::ST_READ) rd_idx <= rd_idx + 1'b1;
      else if (state == bis_pkg::ST_ADDR) rd_idx <= '0;
      if (state == bis_pkg::ST_BLEND) begin
        if (xc + 1'b1 >= tw) begin
          out_column <= '0;
          out_row <= (yc + 1'b1 >= th) ? '0 : yc + 1'b1;
        end else begin
          out_column <= xc + 1'b1;
          out_row <= yc;
        end
      end
    end
  end

  // payload registers: positions, corners, captured pixels
  logic [NW-FRAC_BITS-1:0] xint;
  logic [NW-FRAC_BITS-1:0] yint;
  assign xint = xi[NW-1:FRAC_BITS];
  assign yint = yi[NW-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (state == bis_pkg::ST_DIV && div_done && !axis) xf <= quo;
    if (state == bis_pkg::ST_DIV && div_done && axis) begin
      yf <= yi;
      xf <= xi;
      x0 <= (xint > (NW-FRAC_BITS)'(sw - 1'b1)) ? sw - 1'b1 : SWW'(xint);
      y0 <= (yint > (NW-FRAC_BITS)'(sh - 1'b1)) ? sh - 1'b1 : SHW'(yint);
    end
    if (state == bis_pkg::ST_ADDR) begin
      x1 <= (x0 + 1'b1 < sw) ? x0 + 1'b1 : sw - 1'b1;
      y1 <= (y0 + 1'b1 < sh) ? y0 + 1'b1 : sh - 1'b1;
      last_r <= (xc == tw - 1'b1) && (yc == th - 1'b1);
    end
    // read data is registered, so it arrives in the cycle after its address
    if (state == bis_pkg::ST_READ && rd_idx != 2'd0) px[rd_idx - 1'b1] <= rd_data;
    if (state == bis_pkg::ST_WAIT) px[3] <= rd_data;
  end

  // four channel lanes side by side, merged into the result transaction
  logic [7:0] lane_pix [4];
  for (genvar c = 0; c < 4; c++) begin : g_lane
    bis_lane #(.FB(FRAC_BITS)) u_lane (
      .clk(clk),
      .p00(px[0][8*c +: 8]), .p10(px[1][8*c +: 8]),
      .p01(px[2][8*c +: 8]), .p11(px[3][8*c +: 8]),
      .fx(xf[FRAC_BITS-1:0]), .fy(yf[FRAC_BITS-1:0]),
      .pix(lane_pix[c])
    );
  end

  // lanes register horizontal blend at ST_HORZ->ST_BLEND edge; vertical is combinational
  always_ff @(posedge clk) begin
    if (state == bis_pkg::ST_BLEND) begin
      out_item.out_red    <= lane_pix[0];
      out_item.out_green  <= lane_pix[1];
      out_item.out_blue   <= lane_pix[2];
      out_item.out_alpha  <= lane_pix[3];
      out_item.last_pixel <= last_r;
    end
  end
endmodule

@@ dv/testbench.sv @@
// self-checking testbench for bilinear_rgba_image_scaler
// directed corner table then random phases of size writes, image loads and emits
// depends on bis_pkg and the scaler rtl
module testbench;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 120;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  bis_pkg::in_item_t in_item;
  logic done;
  bis_pkg::out_item_t out_item;
  logic cfg_we;
  logic [bis_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data;

  bilinear_rgba_image_scaler u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .done(done), .out_item(out_item), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow copy of the scaler state
  bit [31:0] pixel_mem [bis_pkg::MAX_SRC_WIDTH*bis_pkg::MAX_SRC_HEIGHT];
  int unsigned load_ptr, col_ptr, row_ptr;
  int unsigned src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;

  bis_pkg::out_item_t pending_pixels[$];
  int errors, loads_sent, emits_sent, pixels_seen, phases, idle_cycles;

  // directed rows: 2x2 source onto 2x2 target, corners map one to one
  typedef struct packed {
    bis_pkg::in_item_t  item;
    bit                 typed;
    bis_pkg::out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows [11] = '{
    '{'{bis_pkg::CMD_LOAD, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
    '{'{bis_pkg::CMD_LOAD, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
    '{'{bis_pkg::CMD_LOAD, 8'h01, 8'h80, 8'h7f, 8'hfe}, 1'b0, '0},
    '{'{bis_pkg::CMD_LOAD, 8'ha5, 8'h5a, 8'h0f, 8'hf0}, 1'b0, '0},
    '{'{bis_pkg::CMD_EMIT, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
      '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
    '{'{bis_pkg::CMD_EMIT, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
      '{8'hff, 8'hff, 8'hff, 8'hff, 1'b0}},
    '{'{bis_pkg::CMD_EMIT, 8'h55, 8'haa, 8'h55, 8'haa}, 1'b1,
      '{8'h01, 8'h80, 8'h7f, 8'hfe, 1'b0}},
    '{'{bis_pkg::CMD_EMIT, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
      '{8'ha5, 8'h5a, 8'h0f, 8'hf0, 1'b1}},
    // emit wraps back to the first corner, load wraps over the first entry
    '{'{bis_pkg::CMD_EMIT, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
    '{'{bis_pkg::CMD_LOAD, 8'h10, 8'h20, 8'h30, 8'h40}, 1'b0, '0},
    '{'{bis_pkg::CMD_EMIT, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0}
  };

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned mx);
    if (v < 1) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  // 16.16 source coordinate of a target index, corners aligned
  function automatic longint unsigned source_coord(int unsigned t, int unsigned s,
                                                   int unsigned d);
    longint unsigned prod;
    if (d <= 1) return 0;
    prod = 64'(t) * 64'(s - 1);
    return (prod << bis_pkg::FRAC_BITS) / 64'(d - 1);
  endfunction

  function automatic int unsigned lerp_round(int unsigned a, int unsigned b,
                                             int unsigned f);
    return (a * ((1 << bis_pkg::FRAC_BITS) - f) + b * f + (1 << (bis_pkg::FRAC_BITS - 1)))
           >> bis_pkg::FRAC_BITS;
  endfunction

  function automatic void store_source_pixel(bis_pkg::in_item_t it);
    int unsigned sw, sh, total, pos;
    sw = clamp_dim(src_w_reg, bis_pkg::MAX_SRC_WIDTH);
    sh = clamp_dim(src_h_reg, bis_pkg::MAX_SRC_HEIGHT);
    total = sw * sh;
    pos = (load_ptr < total) ? load_ptr : 0;
    pixel_mem[pos] = {it.in_alpha, it.in_blue, it.in_green, it.in_red};
    pos++;
    load_ptr = (pos >= total) ? 0 : pos;
  endfunction

  function automatic bis_pkg::out_item_t resample_next_pixel();
    int unsigned sw, sh, tw, th, x, y, x0, y0, x1, y1, fx, fy, top, bot;
    longint unsigned xf, yf;
    bit [31:0] p00, p10, p01, p11;
    bit [7:0] ch [4];
    bis_pkg::out_item_t r;
    sw = clamp_dim(src_w_reg, bis_pkg::MAX_SRC_WIDTH);
    sh = clamp_dim(src_h_reg, bis_pkg::MAX_SRC_HEIGHT);
    tw = clamp_dim(dst_w_reg, bis_pkg::MAX_DST_WIDTH);
    th = clamp_dim(dst_h_reg, bis_pkg::MAX_DST_HEIGHT);
    x = (col_ptr < tw) ? col_ptr : 0;
    y = (row_ptr < th) ? row_ptr : 0;
    xf = source_coord(x, sw, tw);
    yf = source_coord(y, sh, th);
    x0 = 32'(xf >> bis_pkg::FRAC_BITS);
    y0 = 32'(yf >> bis_pkg::FRAC_BITS);
    fx = 32'(xf & ((64'd1 << bis_pkg::FRAC_BITS) - 1));
    fy = 32'(yf & ((64'd1 << bis_pkg::FRAC_BITS) - 1));
    if (x0 > sw - 1) x0 = sw - 1;
    if (y0 > sh - 1) y0 = sh - 1;
    x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
    y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
    p00 = pixel_mem[y0 * sw + x0];
    p10 = pixel_mem[y0 * sw + x1];
    p01 = pixel_mem[y1 * sw + x0];
    p11 = pixel_mem[y1 * sw + x1];
    for (int c = 0; c < 4; c++) begin
      top = lerp_round(32'(p00[c*8 +: 8]), 32'(p10[c*8 +: 8]), fx);
      bot = lerp_round(32'(p01[c*8 +: 8]), 32'(p11[c*8 +: 8]), fx);
      ch[c] = 8'(lerp_round(top, bot, fy));
    end
    r.out_red = ch[0];
    r.out_green = ch[1];
    r.out_blue = ch[2];
    r.out_alpha = ch[3];
    r.last_pixel = (x == tw - 1) && (y == th - 1);
    x++;
    if (x >= tw) begin
      x = 0;
      y++;
      if (y >= th) y = 0;
    end
    col_ptr = x;
    row_ptr = y;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on pixel %0d: %s got %0h expected %0h", pixels_seen, what, got, want);
    errors++;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result checker: done is a one-cycle strobe, taken at the edge that ends it
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected strobe", 1, 0);
      end else begin
        bis_pkg::out_item_t want;
        want = pending_pixels.pop_front();
        if (out_item.out_red !== want.out_red)
          report_mismatch("red", out_item.out_red, want.out_red);
        if (out_item.out_green !== want.out_green)
          report_mismatch("green", out_item.out_green, want.out_green);
        if (out_item.out_blue !== want.out_blue)
          report_mismatch("blue", out_item.out_blue, want.out_blue);
        if (out_item.out_alpha !== want.out_alpha)
          report_mismatch("alpha", out_item.out_alpha, want.out_alpha);
        if (out_item.last_pixel !== want.last_pixel)
          report_mismatch("last", out_item.last_pixel, want.last_pixel);
      end
      pixels_seen++;
    end
  end

  // watchdog: cycles with no transaction and no result
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d pixels still pending", pending_pixels.size());
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // hold start high until the transaction is taken; start stays high on return
  task automatic send_item(bis_pkg::in_item_t it, bit typed, bis_pkg::out_item_t want);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    if (it.command == bis_pkg::CMD_LOAD) begin
      store_source_pixel(it);
      loads_sent++;
    end else begin
      bis_pkg::out_item_t predicted;
      predicted = resample_next_pixel();
      pending_pixels.push_back(typed ? want : predicted);
      emits_sent++;
    end
  endtask

  task automatic random_gap();
    int unsigned r, n;
    r = $urandom_range(0, 9);
    n = (r < 6) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop sending and wait out every pending pixel plus the emit latency
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [bis_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= bis_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bis_pkg::REG_SRC_W: src_w_reg = val & 11'h7ff;
      bis_pkg::REG_SRC_H: src_h_reg = val & 10'h3ff;
      bis_pkg::REG_DST_W: dst_w_reg = val & 11'h7ff;
      default:            dst_h_reg = val & 10'h3ff;
    endcase
  endtask

  task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned tw,
                           int unsigned th);
    write_reg(bis_pkg::REG_SRC_W, sw);
    write_reg(bis_pkg::REG_SRC_H, sh);
    write_reg(bis_pkg::REG_DST_W, tw);
    write_reg(bis_pkg::REG_DST_H, th);
  endtask

  function automatic bis_pkg::in_item_t random_pixel(logic cmd);
    bis_pkg::in_item_t it;
    it = {cmd, 32'($urandom)};
    return it;
  endfunction

  initial begin
    int random_items, sw, sh, tw, th, total, n_items, kind;
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    load_ptr = 0;
    col_ptr = 0;
    row_ptr = 0;
    src_w_reg = 1024;
    src_h_reg = 256;
    dst_w_reg = 512;
    dst_h_reg = 128;
    errors = 0;
    loads_sent = 0;
    emits_sent = 0;
    pixels_seen = 0;
    phases = 0;
    random_items = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    set_sizes(2, 2, 2, 2);
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      random_gap();
    end
    drain();

    // random phases: new sizes, a full image load, then mixed emits and reloads
    while (random_items < 600) begin
      kind = $urandom_range(0, 9);
      sw = $urandom_range(0, 8);
      sh = $urandom_range(0, 8);
      tw = $urandom_range(0, 12);
      th = $urandom_range(0, 12);
      if (kind == 0) begin
        // zero source sizes act as one
        case ($urandom_range(0, 2))
          0: sw = 0;
          1: sh = 0;
          default: begin sw = 0; sh = 0; end
        endcase
      end else if (kind == 1) begin
        // zero and oversize target sizes
        case ($urandom_range(0, 2))
          0: begin tw = 2047; th = 1; end
          1: begin tw = 1; th = 1023; end
          default: begin tw = 1024; th = 0; end
        endcase
      end
      set_sizes(sw, sh, tw, th);
      phases++;
      total = clamp_dim(sw & 11'h7ff, bis_pkg::MAX_SRC_WIDTH) *
              clamp_dim(sh & 10'h3ff, bis_pkg::MAX_SRC_HEIGHT);
      // every entry the emits can touch is written here
      for (int i = 0; i < total; i++) begin
        send_item(random_pixel(bis_pkg::CMD_LOAD), 1'b0, '0);
        random_gap();
      end
      random_items += total;
      n_items = $urandom_range(1, 60);
      for (int i = 0; i < n_items; i++) begin
        send_item(random_pixel(($urandom_range(0, 9) < 7) ? bis_pkg::CMD_EMIT
                                                           : bis_pkg::CMD_LOAD),
                  1'b0, '0);
        random_gap();
      end
      random_items += n_items;
      drain();
    end

    // final drain: nothing pending, then the emit latency
    drain();
    $display("covered %0d size phases, %0d loads, %0d emits, %0d pixels checked",
             phases, loads_sent, emits_sent, pixels_seen);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ bilinear_rgba_image_scaler.f @@
hdl/bis_pkg.sv
hdl/bis_lane.sv
hdl/bis_div.sv
hdl/bilinear_rgba_image_scaler.sv
dv/testbench.sv
